// ===== rtl/ack_retry_timeout_table_top_assert.svh =====
// ----------------------------------------------------------------------------
// ack_retry_timeout_table_top_assert.svh
// Assertion macros for the port-level checker of the retransmission table.
// ----------------------------------------------------------------------------
`ifndef ACK_RETRY_TIMEOUT_TABLE_TOP_ASSERT_SVH
`define ACK_RETRY_TIMEOUT_TABLE_TOP_ASSERT_SVH

// checked only outside reset
`define ARRT_ASSERT_RUN(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ARRT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/arrt_pkg.sv =====
// ----------------------------------------------------------------------------
// arrt_pkg
// Types and constants of the retransmission table: commands, entries, results.
// ----------------------------------------------------------------------------
package arrt_pkg;

   typedef enum logic [1:0] {
      OP_SEND = 2'd0,
      OP_ACK  = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      EV_STORED    = 3'd0,
      EV_FULL      = 3'd1,
      EV_ACKED     = 3'd2,
      EV_UNMATCHED = 3'd3,
      EV_RESEND    = 3'd4,
      EV_GIVEUP    = 3'd5,
      EV_IDLE      = 3'd6
   } event_type;

   // most entries one tick may expire
   localparam int unsigned MAX_RESULTS = 8;
   localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      op_type      op;
      logic [31:0] id;
      logic [7:0]  tag;
      logic [7:0]  retries;
      logic [15:0] timeout;
      logic [31:0] now;
   } cmd_type;

   typedef struct packed {
      logic [31:0] id;
      logic [7:0]  tag;
      logic [7:0]  retries;
      logic [15:0] timeout;
   } meta_type;

   typedef struct packed {
      event_type   ev;
      logic [31:0] id;
      logic [7:0]  tag;
      logic [7:0]  retries;
      logic [15:0] timeout;
      logic        last;
   } rsp_type;

endpackage

// ===== rtl/arrt_front.sv =====
// ----------------------------------------------------------------------------
// arrt_front
// Accepts command beats, classifies the request code and feeds the queue.
// ----------------------------------------------------------------------------
module arrt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_type,
   input  logic [31:0]       req_pack_id,
   input  logic [7:0]        req_tag,
   input  logic [7:0]        req_retries,
   input  logic [15:0]       req_timeout_ms,
   input  logic [31:0]       req_now_ms,
   input  logic              q_full,
   output logic              q_push,
   output arrt_pkg::cmd_type q_data
);

   logic              cmd_vld_ff, cmd_vld_in;
   arrt_pkg::cmd_type cmd_ff, cmd_in;
   logic              accept;
   logic              known_op;

   assign busy   = cmd_vld_ff && q_full;
   assign q_push = cmd_vld_ff && !q_full;
   assign q_data = cmd_ff;
   assign accept = start && !busy;

   always_comb begin
      unique case (req_type)
         arrt_pkg::OP_SEND, arrt_pkg::OP_ACK, arrt_pkg::OP_TICK: known_op = 1'b1;
         default: known_op = 1'b0;
      endcase
   end

   always_comb begin
      cmd_vld_in = cmd_vld_ff;
      cmd_in     = cmd_ff;
      if (accept) begin
         // drop the unused code: it gives no result
         cmd_vld_in     = known_op;
         cmd_in.op      = arrt_pkg::op_type'(req_type);
         cmd_in.id      = req_pack_id;
         cmd_in.tag     = req_tag;
         cmd_in.retries = req_retries;
         cmd_in.timeout = req_timeout_ms;
         cmd_in.now     = req_now_ms;
      end else if (q_push) begin
         cmd_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_vld_ff <= 1'b0;
      end else begin
         cmd_vld_ff <= cmd_vld_in;
         cmd_ff     <= cmd_in;
      end
   end

endmodule

// ===== rtl/arrt_queue.sv =====
// ----------------------------------------------------------------------------
// arrt_queue
// Short command queue between the front and the table engine.
// ----------------------------------------------------------------------------
module arrt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  arrt_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output arrt_pkg::cmd_type pop_data,
   output logic              empty
);

   localparam int unsigned DEPTH = arrt_pkg::QUEUE_DEPTH;
   localparam int unsigned PW    = arrt_pkg::QPTR_W;
   localparam int unsigned CW    = arrt_pkg::QCNT_W;

   arrt_pkg::cmd_type slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/arrt_back.sv =====
// ----------------------------------------------------------------------------
// arrt_back
// Table engine: scans the entry memory one entry a cycle and emits results.
// ----------------------------------------------------------------------------
module arrt_back #(
   parameter int unsigned TABLE_ENTRIES = 8,
   parameter int unsigned TIME_BITS     = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  arrt_pkg::cmd_type q_data,
   output logic              q_pop,
   output logic              rsp_vld,
   output arrt_pkg::rsp_type rsp
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam int unsigned CW = arrt_pkg::CNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // entry storage, undefined until written; valid bits guard every read
   arrt_pkg::meta_type   meta_mem [TABLE_ENTRIES];
   logic [TIME_BITS-1:0] time_mem [TABLE_ENTRIES];

   state_type            state_ff, state_in;
   arrt_pkg::cmd_type    cmd_ff, cmd_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 issue_done_ff, issue_done_in;
   logic                 eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]     eval_idx_ff, eval_idx_in;
   arrt_pkg::meta_type   meta_rd_ff;
   logic [TIME_BITS-1:0] time_rd_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 pend_vld_ff, pend_vld_in;
   arrt_pkg::rsp_type    pend_ff, pend_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   arrt_pkg::rsp_type    rsp_ff, rsp_in;

   logic                 issue;
   logic                 mem_we;
   logic                 ent_valid;
   logic                 last_ent;
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] elapsed;
   logic                 expired;

   assign rsp_vld   = rsp_vld_ff;
   assign rsp       = rsp_ff;
   assign ent_valid = valid_ff[eval_idx_ff];
   assign last_ent  = (eval_idx_ff == LAST_IDX);
   assign now_t     = TIME_BITS'(cmd_ff.now);
   assign elapsed   = now_t - time_rd_ff;
   assign expired   = (elapsed >= TIME_BITS'(meta_rd_ff.timeout));

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      issue_done_in = issue_done_ff;
      eval_vld_in   = 1'b0;
      eval_idx_in   = idx_ff;
      valid_in      = valid_ff;
      cnt_in        = cnt_ff;
      pend_vld_in   = pend_vld_ff;
      pend_in       = pend_ff;
      rsp_vld_in    = 1'b0;
      rsp_in        = rsp_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      issue         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop         = 1'b1;
               cmd_in        = q_data;
               idx_in        = '0;
               issue_done_in = 1'b0;
               cnt_in        = '0;
               pend_vld_in   = 1'b0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            issue = !issue_done_ff;
            if (eval_vld_ff) begin
               unique case (cmd_ff.op)
                  arrt_pkg::OP_SEND: begin
                     if (!ent_valid) begin
                        valid_in[eval_idx_ff] = 1'b1;
                        mem_we        = 1'b1;
                        rsp_vld_in    = 1'b1;
                        rsp_in.ev     = arrt_pkg::EV_STORED;
                        rsp_in.id     = cmd_ff.id;
                        rsp_in.tag    = cmd_ff.tag;
                        rsp_in.retries = cmd_ff.retries;
                        rsp_in.timeout = cmd_ff.timeout;
                        rsp_in.last   = 1'b1;
                        state_in      = ST_IDLE;
                        issue         = 1'b0;
                     end else if (last_ent) begin
                        rsp_vld_in    = 1'b1;
                        rsp_in.ev     = arrt_pkg::EV_FULL;
                        rsp_in.id     = cmd_ff.id;
                        rsp_in.tag    = cmd_ff.tag;
                        rsp_in.retries = cmd_ff.retries;
                        rsp_in.timeout = cmd_ff.timeout;
                        rsp_in.last   = 1'b1;
                        state_in      = ST_IDLE;
                     end
                  end

                  arrt_pkg::OP_ACK: begin
                     if (ent_valid && (meta_rd_ff.id == cmd_ff.id)) begin
                        valid_in[eval_idx_ff] = 1'b0;
                        rsp_vld_in    = 1'b1;
                        rsp_in.ev     = arrt_pkg::EV_ACKED;
                        rsp_in.id     = meta_rd_ff.id;
                        rsp_in.tag    = meta_rd_ff.tag;
                        rsp_in.retries = meta_rd_ff.retries;
                        rsp_in.timeout = meta_rd_ff.timeout;
                        rsp_in.last   = 1'b1;
                        state_in      = ST_IDLE;
                        issue         = 1'b0;
                     end else if (last_ent) begin
                        rsp_vld_in    = 1'b1;
                        rsp_in.ev     = arrt_pkg::EV_UNMATCHED;
                        rsp_in.id     = cmd_ff.id;
                        rsp_in.tag    = '0;
                        rsp_in.retries = '0;
                        rsp_in.timeout = '0;
                        rsp_in.last   = 1'b1;
                        state_in      = ST_IDLE;
                     end
                  end

                  arrt_pkg::OP_TICK: begin
                     if (ent_valid && expired) begin
                        valid_in[eval_idx_ff] = 1'b0;
                        cnt_in         = cnt_ff + CW'(1);
                        pend_vld_in    = 1'b1;
                        pend_in.id     = meta_rd_ff.id;
                        pend_in.tag    = meta_rd_ff.tag;
                        pend_in.timeout = meta_rd_ff.timeout;
                        pend_in.last   = 1'b0;
                        if (meta_rd_ff.retries != '0) begin
                           pend_in.ev      = arrt_pkg::EV_RESEND;
                           pend_in.retries = meta_rd_ff.retries - 8'd1;
                        end else begin
                           pend_in.ev      = arrt_pkg::EV_GIVEUP;
                           pend_in.retries = '0;
                        end
                        // a later hit proves the held one is not the last
                        if (pend_vld_ff) begin
                           rsp_vld_in = 1'b1;
                           rsp_in     = pend_ff;
                        end
                        if (cnt_ff == CW'(arrt_pkg::MAX_RESULTS - 1)) begin
                           state_in = ST_FLUSH;
                           issue    = 1'b0;
                        end
                     end
                     if (last_ent) begin
                        state_in = ST_FLUSH;
                     end
                  end

                  default: begin
                     state_in = ST_IDLE;
                     issue    = 1'b0;
                  end
               endcase
            end
            if (issue) begin
               eval_vld_in   = 1'b1;
               eval_idx_in   = idx_ff;
               idx_in        = idx_ff + IDX_W'(1);
               issue_done_in = (idx_ff == LAST_IDX);
            end
         end

         ST_FLUSH: begin
            rsp_vld_in = 1'b1;
            if (pend_vld_ff) begin
               rsp_in      = pend_ff;
               rsp_in.last = 1'b1;
            end else begin
               rsp_in.ev      = arrt_pkg::EV_IDLE;
               rsp_in.id      = '0;
               rsp_in.tag     = '0;
               rsp_in.retries = '0;
               rsp_in.timeout = '0;
               rsp_in.last    = 1'b1;
            end
            pend_vld_in = 1'b0;
            state_in    = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // entry memory: one read port for the scan, one write port for stores
   always_ff @(posedge clock) begin
      if (issue) begin
         meta_rd_ff <= meta_mem[idx_ff];
         time_rd_ff <= time_mem[idx_ff];
      end
      if (mem_we) begin
         meta_mem[eval_idx_ff] <= '{id: cmd_ff.id, tag: cmd_ff.tag,
                                    retries: cmd_ff.retries, timeout: cmd_ff.timeout};
         time_mem[eval_idx_ff] <= now_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         eval_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         issue_done_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         cmd_ff        <= cmd_in;
         idx_ff        <= idx_in;
         issue_done_ff <= issue_done_in;
         eval_vld_ff   <= eval_vld_in;
         eval_idx_ff   <= eval_idx_in;
         valid_ff      <= valid_in;
         cnt_ff        <= cnt_in;
         pend_vld_ff   <= pend_vld_in;
         pend_ff       <= pend_in;
         rsp_vld_ff    <= rsp_vld_in;
         rsp_ff        <= rsp_in;
      end
   end

endmodule

// ===== rtl/ack_retry_timeout_table_top.sv =====
// ----------------------------------------------------------------------------
// ack_retry_timeout_table_top
// Retransmission table: stores sent packets, frees them on ack, and expires
// them on time ticks with resend or give-up results.
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// req_      in         start high, busy low     type, id, tag, retries, timeout, now
// rsp_      out        rsp_valid, one cycle     event, id, tag, retries, timeout, last
//
// A command is registered in the front stage, then waits in a two-deep queue.
// The table engine reads one entry a cycle from its entry memory: a send or ack
// stops at the deciding entry; a tick scans until the last entry or until
// MAX_RESULTS entries expire, and gives its results at most one a cycle.
// Reset clears all entry valid bits at once; no clearing pass is needed.
// busy rises only while the front stage holds a beat and the queue is full.
// ----------------------------------------------------------------------------
module ack_retry_timeout_table_top #(
   parameter int unsigned TABLE_ENTRIES = 8,
   parameter int unsigned TIME_BITS     = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_pack_id,
   input  logic [7:0]  req_tag,
   input  logic [7:0]  req_retries,
   input  logic [15:0] req_timeout_ms,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   output logic [2:0]  rsp_event_res,
   output logic [31:0] rsp_out_id,
   output logic [7:0]  rsp_out_tag,
   output logic [7:0]  rsp_out_retries,
   output logic [15:0] rsp_out_timeout,
   output logic        rsp_last
);

   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;
   arrt_pkg::cmd_type q_wdata;
   arrt_pkg::cmd_type q_rdata;
   arrt_pkg::rsp_type rsp;

   arrt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_pack_id    (req_pack_id),
      .req_tag        (req_tag),
      .req_retries    (req_retries),
      .req_timeout_ms (req_timeout_ms),
      .req_now_ms     (req_now_ms),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_wdata)
   );

   arrt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   arrt_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .TIME_BITS     (TIME_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_rdata),
      .q_pop   (q_pop),
      .rsp_vld (rsp_valid),
      .rsp     (rsp)
   );

   assign rsp_event_res   = rsp.ev;
   assign rsp_out_id      = rsp.id;
   assign rsp_out_tag     = rsp.tag;
   assign rsp_out_retries = rsp.retries;
   assign rsp_out_timeout = rsp.timeout;
   assign rsp_last        = rsp.last;

endmodule

// ===== rtl/arrt_checker.sv =====
// ----------------------------------------------------------------------------
// arrt_checker
// Port-level checks of the retransmission table, bound to the top level.
// ----------------------------------------------------------------------------
`include "ack_retry_timeout_table_top_assert.svh"

module arrt_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_event_res,
   input logic [31:0] rsp_out_id,
   input logic [7:0]  rsp_out_tag,
   input logic [7:0]  rsp_out_retries,
   input logic [15:0] rsp_out_timeout,
   input logic        rsp_last
);

   logic out_quiet;
   logic single_beat;
   logic idle_beat;
   logic giveup_beat;
   logic final_beat;
   logic payload_zero;

   assign out_quiet    = !rsp_valid && !busy;
   assign single_beat  = rsp_valid && (rsp_event_res == arrt_pkg::EV_STORED ||
                                       rsp_event_res == arrt_pkg::EV_FULL ||
                                       rsp_event_res == arrt_pkg::EV_ACKED ||
                                       rsp_event_res == arrt_pkg::EV_UNMATCHED ||
                                       rsp_event_res == arrt_pkg::EV_IDLE);
   assign idle_beat    = rsp_valid && (rsp_event_res == arrt_pkg::EV_IDLE);
   assign giveup_beat  = rsp_valid && (rsp_event_res == arrt_pkg::EV_GIVEUP);
   assign final_beat   = rsp_valid && rsp_last;
   assign payload_zero = (rsp_out_id == '0) && (rsp_out_tag == '0) &&
                         (rsp_out_retries == '0) && (rsp_out_timeout == '0);

   // no result beat and busy low right after reset
   `ARRT_ASSERT_ALWAYS(a_quiet_after_reset, $past(reset) |-> out_quiet, "beat after reset")

   // send, ack and idle tick give exactly one beat, so it is the final one
   `ARRT_ASSERT_RUN(a_single_is_last, single_beat |-> rsp_last, "single result without last")

   // an idle tick carries an all-zero payload
   `ARRT_ASSERT_RUN(a_idle_zero, idle_beat |-> payload_zero, "idle result with payload")

   // give-up results carry no retries
   `ARRT_ASSERT_RUN(a_giveup_zero, giveup_beat |-> (rsp_out_retries == '0), "give-up retries")

   // results are spaced by the engine's scan: never two last beats in a row
   `ARRT_ASSERT_RUN(a_last_spacing, final_beat |=> !final_beat, "back-to-back final results")

endmodule

bind ack_retry_timeout_table_top arrt_checker u_arrt_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_event_res   (rsp_event_res),
   .rsp_out_id      (rsp_out_id),
   .rsp_out_tag     (rsp_out_tag),
   .rsp_out_retries (rsp_out_retries),
   .rsp_out_timeout (rsp_out_timeout),
   .rsp_last        (rsp_last)
);

// ===== verif/ack_retry_timeout_table_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ack_retry_timeout_table_checker
// Watches the command and result channels of the retransmission table, keeps
// its own copy of the entries and compares every result beat, in order, with
// the results that the accepted commands call for.
// ----------------------------------------------------------------------------
module ack_retry_timeout_table_checker #(
   parameter int unsigned TABLE_ENTRIES = 8,
   parameter int unsigned TIME_BITS     = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_pack_id,
   input  logic [7:0]  req_tag,
   input  logic [7:0]  req_retries,
   input  logic [15:0] req_timeout_ms,
   input  logic [31:0] req_now_ms,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_event_res,
   input  logic [31:0] rsp_out_id,
   input  logic [7:0]  rsp_out_tag,
   input  logic [7:0]  rsp_out_retries,
   input  logic [15:0] rsp_out_timeout,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending,
   output int          checked,
   output int          resends,
   output int          giveups,
   output int          fulls
);

   localparam bit [63:0] TIME_MASK =
      (TIME_BITS >= 64) ? '1 : ((64'd1 << TIME_BITS) - 64'd1);

   typedef struct {
      bit        valid;
      bit [31:0] id;
      bit [7:0]  tag;
      bit [7:0]  retries;
      bit [15:0] timeout;
      bit [63:0] sent;
   } slot_type;

   slot_type          slots[TABLE_ENTRIES];
   arrt_pkg::rsp_type due_events[$];

   function automatic arrt_pkg::rsp_type make_event(arrt_pkg::event_type ev,
                                                    logic [31:0] id, logic [7:0] tg,
                                                    logic [7:0] rt, logic [15:0] tmo);
      arrt_pkg::rsp_type r;
      r.ev      = ev;
      r.id      = id;
      r.tag     = tg;
      r.retries = rt;
      r.timeout = tmo;
      r.last    = 1'b0;
      return r;
   endfunction

   // update the table for one accepted command and queue the results it owes
   function automatic void apply_command(logic [1:0] op, logic [31:0] id, logic [7:0] tg,
                                         logic [7:0] rt, logic [15:0] tmo, logic [31:0] now);
      arrt_pkg::rsp_type outs[$];
      arrt_pkg::rsp_type r;
      bit [63:0]         now_t;
      bit [63:0]         elapsed;
      bit                found;
      int                k;
      now_t = {32'd0, now} & TIME_MASK;
      found = 1'b0;
      case (op)
         arrt_pkg::OP_SEND: begin
            for (k = 0; k < TABLE_ENTRIES && !found; k++) begin
               if (!slots[k].valid) begin
                  slots[k].valid   = 1'b1;
                  slots[k].id      = id;
                  slots[k].tag     = tg;
                  slots[k].retries = rt;
                  slots[k].timeout = tmo;
                  slots[k].sent    = now_t;
                  found = 1'b1;
               end
            end
            if (found) outs = {outs, make_event(arrt_pkg::EV_STORED, id, tg, rt, tmo)};
            else outs = {outs, make_event(arrt_pkg::EV_FULL, id, tg, rt, tmo)};
         end
         arrt_pkg::OP_ACK: begin
            for (k = 0; k < TABLE_ENTRIES && !found; k++) begin
               if (slots[k].valid && slots[k].id == id) begin
                  slots[k].valid = 1'b0;
                  outs = {outs, make_event(arrt_pkg::EV_ACKED, slots[k].id, slots[k].tag,
                                           slots[k].retries, slots[k].timeout)};
                  found = 1'b1;
               end
            end
            if (!found)
               outs = {outs, make_event(arrt_pkg::EV_UNMATCHED, id, 8'd0, 8'd0, 16'd0)};
         end
         arrt_pkg::OP_TICK: begin
            // lowest expired entries first, never more than one tick may report
            for (k = 0; k < TABLE_ENTRIES && outs.size() < arrt_pkg::MAX_RESULTS; k++) begin
               elapsed = (now_t - slots[k].sent) & TIME_MASK;
               if (slots[k].valid && elapsed >= {48'd0, slots[k].timeout}) begin
                  slots[k].valid = 1'b0;
                  if (slots[k].retries != 8'd0)
                     outs = {outs, make_event(arrt_pkg::EV_RESEND, slots[k].id, slots[k].tag,
                                              slots[k].retries - 8'd1, slots[k].timeout)};
                  else
                     outs = {outs, make_event(arrt_pkg::EV_GIVEUP, slots[k].id, slots[k].tag,
                                              8'd0, slots[k].timeout)};
               end
            end
            if (outs.size() == 0)
               outs = {outs, make_event(arrt_pkg::EV_IDLE, 32'd0, 8'd0, 8'd0, 16'd0)};
         end
         default: begin
            // unused code: drop
         end
      endcase
      for (k = 0; k < outs.size(); k++) begin
         r = outs[k];
         r.last = (k == outs.size() - 1);
         due_events = {due_events, r};
      end
   endfunction

   function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      arrt_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (due_events.size() == 0) begin
               $error("result beat with no command waiting for it: event %0d, id %0h",
                      rsp_event_res, rsp_out_id);
               fail_count++;
            end else begin
               want = due_events.pop_front();
               compare_field("event_res", 32'(want.ev), 32'(rsp_event_res));
               compare_field("out_id", want.id, rsp_out_id);
               compare_field("out_tag", 32'(want.tag), 32'(rsp_out_tag));
               compare_field("out_retries", 32'(want.retries), 32'(rsp_out_retries));
               compare_field("out_timeout", 32'(want.timeout), 32'(rsp_out_timeout));
               compare_field("last", 32'(want.last), 32'(rsp_last));
               checked++;
               case (want.ev)
                  arrt_pkg::EV_RESEND: resends++;
                  arrt_pkg::EV_GIVEUP: giveups++;
                  arrt_pkg::EV_FULL:   fulls++;
                  default: ;
               endcase
            end
         end
         if (start && !busy)
            apply_command(req_type, req_pack_id, req_tag, req_retries, req_timeout_ms,
                          req_now_ms);
         pending = due_events.size();
      end
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives send, ack and tick commands into the retransmission table: a directed
// opening over the field extremes, full table, wrap-around and multi-entry
// expiry, then random traffic with random gaps. The checker beside the block
// compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

   localparam int         RANDOM_ITEMS = 200;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         DRAIN_CYCLES = 64;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_type;
   logic [31:0] req_pack_id;
   logic [7:0]  req_tag;
   logic [7:0]  req_retries;
   logic [15:0] req_timeout_ms;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic [2:0]  rsp_event_res;
   logic [31:0] rsp_out_id;
   logic [7:0]  rsp_out_tag;
   logic [7:0]  rsp_out_retries;
   logic [15:0] rsp_out_timeout;
   logic        rsp_last;

   int fail_count;
   int pending;
   int checked;
   int resends;
   int giveups;
   int fulls;
   int cycle_count;
   int n_send;
   int n_ack;
   int n_tick;
   int n_unused;

   logic [31:0] cur_ms;
   logic [31:0] live_ids[$];

   ack_retry_timeout_table_top DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_pack_id     (req_pack_id),
      .req_tag         (req_tag),
      .req_retries     (req_retries),
      .req_timeout_ms  (req_timeout_ms),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_event_res   (rsp_event_res),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_out_retries (rsp_out_retries),
      .rsp_out_timeout (rsp_out_timeout),
      .rsp_last        (rsp_last)
   );

   ack_retry_timeout_table_checker table_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_pack_id     (req_pack_id),
      .req_tag         (req_tag),
      .req_retries     (req_retries),
      .req_timeout_ms  (req_timeout_ms),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_event_res   (rsp_event_res),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_out_retries (rsp_out_retries),
      .rsp_out_timeout (rsp_out_timeout),
      .rsp_last        (rsp_last),
      .fail_count      (fail_count),
      .pending         (pending),
      .checked         (checked),
      .resends         (resends),
      .giveups         (giveups),
      .fulls           (fulls)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // hold start low for the given gap, then present one beat until it is taken
   task automatic issue_cmd(logic [1:0] op, logic [31:0] id, logic [7:0] tg, logic [7:0] rt,
                            logic [15:0] tmo, logic [31:0] now, int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start          <= 1'b1;
      req_type       <= op;
      req_pack_id    <= id;
      req_tag        <= tg;
      req_retries    <= rt;
      req_timeout_ms <= tmo;
      req_now_ms     <= now;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int          n;
      int          k;
      int          gap;
      int          roll;
      int          pick;
      bit          burst;
      bit          paused_mid;
      logic [31:0] id;
      logic [7:0]  rt;
      logic [15:0] tmo;

      reset          = 1'b1;
      start          = 1'b0;
      req_type       = arrt_pkg::OP_SEND;
      req_pack_id    = 32'd0;
      req_tag        = 8'd0;
      req_retries    = 8'd0;
      req_timeout_ms = 16'd0;
      req_now_ms     = 32'd0;
      cycle_count    = 0;
      burst          = 1'b0;
      paused_mid     = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening
      issue_cmd(arrt_pkg::OP_TICK, 32'd0, 8'd0, 8'd0, 16'd0, 32'd0, 0);  // empty table idles
      issue_cmd(arrt_pkg::OP_ACK, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
      issue_cmd(arrt_pkg::OP_SEND, 32'd0, 8'd0, 8'd0, 16'd0, 32'd0, 0);
      issue_cmd(arrt_pkg::OP_SEND, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1);
      issue_cmd(arrt_pkg::OP_SEND, 32'd0, 8'd1, 8'd1, 16'd5, 32'd0, 0);  // duplicate id
      issue_cmd(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
      issue_cmd(arrt_pkg::OP_ACK, 32'd0, 8'd0, 8'd0, 16'd0, 32'd0, 0);   // frees the first only
      issue_cmd(arrt_pkg::OP_TICK, 32'd0, 8'd0, 8'd0, 16'd0, 32'd0, 2);
      issue_cmd(arrt_pkg::OP_TICK, 32'd0, 8'd0, 8'd0, 16'd0, 32'd5, 0);
      for (k = 0; k < 7; k++)
         issue_cmd(arrt_pkg::OP_SEND, 32'h100 + 32'(k), 8'(k * 37), 8'(k % 2), 16'(k * 3),
                   32'd10, 0);
      // table full
      issue_cmd(arrt_pkg::OP_SEND, 32'h5A5A_A5A5, 8'h3C, 8'h07, 16'h1234, 32'd11, 0);
      // wraps past the send at all-ones time and expires all eight entries
      issue_cmd(arrt_pkg::OP_TICK, 32'd0, 8'd0, 8'd0, 16'd0, 32'h0000_FFFE, 0);
      issue_cmd(arrt_pkg::OP_TICK, 32'd0, 8'd0, 8'd0, 16'd0, 32'h0000_FFFE, 0);
      issue_cmd(arrt_pkg::OP_ACK, 32'd0, 8'd0, 8'd0, 16'd0, 32'd0, 1);
      n_send = 11;
      n_ack  = 3;
      n_tick = 5;
      n_unused = 1;
      drain_results();

      // random traffic, starting just below the time wrap
      cur_ms = 32'hFFFF_FF80;
      for (n = 0; n < RANDOM_ITEMS; ) begin
         if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2 && !paused_mid) begin
            drain_results();
            paused_mid = 1'b1;
         end
         roll = $urandom_range(0, 99);
         gap  = 0;
         if (!burst) begin
            if (roll >= 88) gap = $urandom_range(8, 40);
            else if (roll >= 55) gap = $urandom_range(1, 3);
         end
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            issue_cmd(OP_UNUSED, $urandom, 8'($urandom), 8'($urandom), 16'($urandom),
                      $urandom, gap);
            n_unused++;
         end else if (roll < 45) begin
            cur_ms = cur_ms + 32'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 15 && live_ids.size() > 0)
               id = live_ids[$urandom_range(0, live_ids.size() - 1)];
            else if (pick < 30)
               id = 32'($urandom_range(0, 15));
            else
               id = $urandom;
            rt = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 70) tmo = 16'($urandom_range(0, 30));
            else if (pick < 90) tmo = 16'($urandom_range(31, 500));
            else tmo = 16'($urandom);
            issue_cmd(arrt_pkg::OP_SEND, id, 8'($urandom), rt, tmo, cur_ms, gap);
            live_ids = {live_ids, id};
            if (live_ids.size() > 16) void'(live_ids.pop_front());
            n_send++;
            n++;
         end else if (roll < 70) begin
            if (live_ids.size() > 0 && $urandom_range(0, 99) < 62) begin
               k  = $urandom_range(0, live_ids.size() - 1);
               id = live_ids[k];
               live_ids.delete(k);
            end else begin
               id = $urandom;
            end
            issue_cmd(arrt_pkg::OP_ACK, id, 8'($urandom), 8'($urandom), 16'($urandom),
                      $urandom, gap);
            n_ack++;
            n++;
         end else begin
            // mostly small steps; now and then a long jump or a jump anywhere
            pick = $urandom_range(0, 99);
            if (pick < 80) cur_ms = cur_ms + 32'($urandom_range(0, 25));
            else if (pick < 95) cur_ms = cur_ms + 32'($urandom_range(100, 3000));
            else cur_ms = $urandom;
            issue_cmd(arrt_pkg::OP_TICK, $urandom, 8'($urandom), 8'($urandom), 16'($urandom),
                      cur_ms, gap);
            n_tick++;
            n++;
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Drove %0d sends, %0d acks, %0d ticks and %0d unused-code commands.",
               n_send, n_ack, n_tick, n_unused);
      $display("Checked %0d result beats: %0d resends, %0d give-ups, %0d table-full reports.",
               checked, resends, giveups, fulls);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
